// File: src/assert_macros.svh
// assertion helpers used by cfla_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in a cycle implies consequent in the following cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cfla_pkg.sv
// ----------------------------------------------------------------------------
// cfla_pkg
// Shared constants, codes and payload types of the chunk free list allocator.
// ----------------------------------------------------------------------------
package cfla_pkg;

  localparam int NUM_CHUNKS      = 64;
  localparam int WORDS_PER_CHUNK = 16;
  localparam int MEM_WORDS       = NUM_CHUNKS * WORDS_PER_CHUNK;
  localparam int IDX_W           = $clog2(MEM_WORDS);
  localparam int CHUNK_W         = $clog2(NUM_CHUNKS);
  localparam int ZCNT_W          = (WORDS_PER_CHUNK > 1) ? $clog2(WORDS_PER_CHUNK) : 1;
  localparam int CHUNK_BYTES     = WORDS_PER_CHUNK * 4;
  localparam int POOL_BYTES      = MEM_WORDS * 4;

  localparam logic [31:0] BASE_RESET = 32'd4096;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_OOM   = 2'd1,
    FAULT_RANGE = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_AREAD,
    ST_AZERO,
    ST_FREE,
    ST_DONE
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] chunk_address;
  } in_t;

  typedef struct packed {
    logic [31:0] alloc_address;
    fault_t      fault;
    logic [15:0] allocated_count;
    logic [31:0] free_head;
  } out_t;

  // result of mapping a byte address onto the pool memory
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } map_t;

endpackage

// File: src/chunk_free_list_allocator.sv
// ----------------------------------------------------------------------------
// chunk_free_list_allocator
// Fixed-size chunk allocator with a free list linked through the pool memory.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_data: pool_base
//  in      | in_valid / in_ready   | in_data: mode, chunk_address
//  out     | out_valid / out_ready | out_data: alloc_address, fault,
//          |                       |   allocated_count, free_head
//
// one item at a time; the next item is taken only after the last result enters the output register:
//   init chains the pool, one link word written per cycle
//   alloc does one read, then one word cleared per cycle
//   free writes one link word; empty-list alloc and no-op only report a result
// the single memory port serialises these steps; no clearing pass after reset
// a stalled output holds the finished result and in_ready stays low meanwhile
// ----------------------------------------------------------------------------
module chunk_free_list_allocator (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  cfla_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cfla_pkg::out_t  out_data
);

  logic [31:0]    pool_base;
  logic           res_valid;
  logic           res_ready;
  cfla_pkg::out_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= cfla_pkg::BASE_RESET;
    end else if (cfg_valid) begin
      pool_base <= cfg_data;
    end
  end

  cfla_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .pool_base  (pool_base),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data <= res;
  end

endmodule

// File: src/cfla_map.sv
// ----------------------------------------------------------------------------
// cfla_map
// Maps a byte address onto a pool word index and flags addresses that fall
// outside the pool memory.
// ----------------------------------------------------------------------------
module cfla_map (
  input  logic [33:0]       addr,
  input  logic [31:0]       base,
  output cfla_pkg::map_t    map
);

  logic        above;
  logic [31:0] word_diff;

  assign above     = addr >= {2'b00, base};
  assign word_diff = addr[33:2] - {2'b00, base[31:2]};

  assign map.hit = above && (word_diff < 32'(cfla_pkg::MEM_WORDS));
  assign map.idx = word_diff[cfla_pkg::IDX_W-1:0];

endmodule

// File: src/cfla_engine.sv
// ----------------------------------------------------------------------------
// cfla_engine
// Sequencer around the single-port pool memory: chains the pool on init,
// pops and clears a chunk on alloc, pushes a chunk on free.
// ----------------------------------------------------------------------------
module cfla_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          pool_base,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  cfla_pkg::in_t        item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output cfla_pkg::out_t       res
);

  cfla_pkg::state_t state, state_next;

  // control state
  logic [31:0] head;
  logic [15:0] count;

  // per item datapath
  logic [31:0]                   caddr;
  logic [31:0]                   got;
  cfla_pkg::fault_t              fault_q;
  logic [31:0]                   link_acc;
  logic [cfla_pkg::CHUNK_W-1:0]  init_cnt;
  logic [cfla_pkg::IDX_W-1:0]    init_idx;
  logic [33:0]                   zaddr;
  logic [cfla_pkg::ZCNT_W-1:0]   zcnt;
  logic                          rd_hit;

  // pool memory
  logic [31:0]                   mem [cfla_pkg::MEM_WORDS];
  logic [31:0]                   rdata;
  logic                          mem_we;
  logic                          mem_re;
  logic [cfla_pkg::IDX_W-1:0]    mem_idx;
  logic [31:0]                   mem_wdata;

  logic [33:0]                   map_addr;
  cfla_pkg::map_t                map;
  logic [32:0]                   pool_end;
  logic                          in_range;
  logic                          init_last;
  logic                          zero_last;

  cfla_map u_map (
    .addr (map_addr),
    .base (pool_base),
    .map  (map)
  );

  assign pool_end  = {1'b0, pool_base} + 33'(cfla_pkg::POOL_BYTES);
  assign in_range  = (caddr >= pool_base) && ({1'b0, caddr} < pool_end);
  assign init_last = init_cnt == cfla_pkg::CHUNK_W'(cfla_pkg::NUM_CHUNKS - 1);
  assign zero_last = zcnt == cfla_pkg::ZCNT_W'(cfla_pkg::WORDS_PER_CHUNK - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cfla_pkg::ST_IDLE: begin
        if (item_valid) begin
          case (item.mode)
            cfla_pkg::MODE_INIT:  state_next = cfla_pkg::ST_INIT;
            cfla_pkg::MODE_ALLOC: state_next = (head != 32'd0) ? cfla_pkg::ST_AREAD
                                                               : cfla_pkg::ST_DONE;
            cfla_pkg::MODE_FREE:  state_next = cfla_pkg::ST_FREE;
            default:              state_next = cfla_pkg::ST_DONE;
          endcase
        end
      end
      cfla_pkg::ST_INIT:  if (init_last) state_next = cfla_pkg::ST_DONE;
      cfla_pkg::ST_AREAD: state_next = cfla_pkg::ST_AZERO;
      cfla_pkg::ST_AZERO: if (zero_last) state_next = cfla_pkg::ST_DONE;
      cfla_pkg::ST_FREE:  state_next = cfla_pkg::ST_DONE;
      cfla_pkg::ST_DONE:  if (res_ready) state_next = cfla_pkg::ST_IDLE;
      default:            state_next = cfla_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory port
  always_comb begin
    item_ready = 1'b0;
    res_valid  = 1'b0;
    map_addr   = {2'b00, caddr};
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_idx    = map.idx;
    mem_wdata  = 32'd0;
    case (state)
      cfla_pkg::ST_IDLE: item_ready = 1'b1;
      cfla_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_idx   = init_idx;
        mem_wdata = init_last ? 32'd0 : link_acc;
      end
      cfla_pkg::ST_AREAD: begin
        map_addr = {2'b00, head};
        mem_re   = map.hit;
      end
      cfla_pkg::ST_AZERO: begin
        map_addr = zaddr;
        mem_we   = map.hit;
      end
      cfla_pkg::ST_FREE: begin
        mem_we    = in_range && map.hit;
        mem_wdata = head;
      end
      cfla_pkg::ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfla_pkg::ST_IDLE;
      head  <= 32'd0;
      count <= 16'd0;
    end else begin
      state <= state_next;
      case (state)
        cfla_pkg::ST_INIT: begin
          if (init_last) begin
            head  <= pool_base;
            count <= 16'd0;
          end
        end
        cfla_pkg::ST_AZERO: begin
          // link was read before the chunk gets cleared
          if (zcnt == '0) head <= rd_hit ? rdata : 32'd0;
          if (zero_last && count != 16'hFFFF) count <= count + 16'd1;
        end
        cfla_pkg::ST_FREE: begin
          if (in_range) begin
            head <= caddr;
            if (count != 16'd0) count <= count - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cfla_pkg::ST_IDLE: begin
        if (item_valid) begin
          caddr    <= item.chunk_address;
          got      <= (item.mode == cfla_pkg::MODE_ALLOC) ? head : 32'd0;
          fault_q  <= (item.mode == cfla_pkg::MODE_ALLOC && head == 32'd0)
                      ? cfla_pkg::FAULT_OOM : cfla_pkg::FAULT_OK;
          link_acc <= pool_base + 32'(cfla_pkg::CHUNK_BYTES);
          init_cnt <= '0;
          init_idx <= '0;
          zaddr    <= {2'b00, head};
          zcnt     <= '0;
        end
      end
      cfla_pkg::ST_INIT: begin
        link_acc <= link_acc + 32'(cfla_pkg::CHUNK_BYTES);
        init_cnt <= init_cnt + cfla_pkg::CHUNK_W'(1);
        init_idx <= init_idx + cfla_pkg::IDX_W'(cfla_pkg::WORDS_PER_CHUNK);
      end
      cfla_pkg::ST_AREAD: rd_hit <= map.hit;
      cfla_pkg::ST_AZERO: begin
        zaddr <= zaddr + 34'd4;
        zcnt  <= zcnt + cfla_pkg::ZCNT_W'(1);
      end
      cfla_pkg::ST_FREE: if (!in_range) fault_q <= cfla_pkg::FAULT_RANGE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_idx] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_idx];
  end

  assign res.alloc_address   = got;
  assign res.fault           = fault_q;
  assign res.allocated_count = count;
  assign res.free_head       = head;

endmodule

// File: src/cfla_checker.sv
// ----------------------------------------------------------------------------
// cfla_checker
// Port-level checks on the allocator results, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfla_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input cfla_pkg::out_t  out_data
);

  logic out_stall;
  logic out_fault;
  logic out_oom;
  logic out_grant;
  logic addr_zero;
  logic head_empty;
  logic count_zero;

  assign out_stall  = out_valid && !out_ready;
  assign out_fault  = out_valid && out_data.fault != cfla_pkg::FAULT_OK;
  assign out_oom    = out_valid && out_data.fault == cfla_pkg::FAULT_OOM;
  assign out_grant  = out_valid && out_data.alloc_address != 32'd0;
  assign addr_zero  = out_data.alloc_address == 32'd0;
  assign head_empty = out_data.free_head == 32'd0;
  assign count_zero = out_data.allocated_count == 16'd0;

  // a stalled result transaction keeps its payload
  `ASSERT_NEXT(a_hold, clk, rst, out_stall, out_valid && $stable(out_data), "held result changed")

  // a faulted item never hands out a chunk
  `ASSERT_IMPLIES(a_fault_no_addr, clk, rst, out_fault, addr_zero, "address given with fault")

  // running out of chunks means the list is empty
  `ASSERT_IMPLIES(a_oom_empty, clk, rst, out_oom, head_empty, "out of chunks with nonempty list")

  // a granted chunk is counted
  `ASSERT_IMPLIES(a_alloc_counted, clk, rst, out_grant, !count_zero, "allocation not counted")

endmodule

bind chunk_free_list_allocator cfla_checker u_checker (.*);

// File: tb/pool_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pool_result_checker
// Watches the config, input and output channels of the chunk allocator,
// keeps its own copy of the pool memory, free list head and allocated count,
// predicts one result per accepted input transaction and compares each
// accepted output transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pool_result_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [31:0]    cfg_data,
  input  logic           in_valid,
  input  logic           in_ready,
  input  cfla_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  cfla_pkg::out_t out_data,
  output int             mismatches,
  output int             in_flight
);
  import cfla_pkg::*;

  logic [31:0] pool_mem [MEM_WORDS];
  logic [31:0] base_addr;
  logic [31:0] list_head;
  logic [15:0] used_chunks;
  out_t        pending_results [$];
  out_t        predicted;
  out_t        oldest;
  int          k;

  // byte address to pool word, low two bits dropped; miss outside the memory
  function automatic bit word_index(input logic [33:0] addr, output int unsigned idx);
    logic [32:0] w;
    idx = 0;
    if (addr < {2'b00, base_addr}) return 1'b0;
    w = {1'b0, addr[33:2]} - {3'b000, base_addr[31:2]};
    if (w >= MEM_WORDS) return 1'b0;
    idx = w[31:0];
    return 1'b1;
  endfunction

  task automatic run_pool_op(input in_t item, output out_t res);
    int unsigned idx;
    logic [32:0] pool_end;
    logic [31:0] got;
    fault_t      flt;
    int          c;
    got = '0;
    flt = FAULT_OK;
    pool_end = {1'b0, base_addr} + POOL_BYTES;
    case (item.mode)
      MODE_INIT: begin
        for (c = 0; c < NUM_CHUNKS - 1; c++)
          pool_mem[c * WORDS_PER_CHUNK] = base_addr + (c + 1) * CHUNK_BYTES;
        pool_mem[(NUM_CHUNKS - 1) * WORDS_PER_CHUNK] = '0;
        list_head = base_addr;
        used_chunks = '0;
      end
      MODE_ALLOC: begin
        if (list_head == '0) begin
          flt = FAULT_OOM;
        end else begin
          got = list_head;
          // a head that no longer maps into the memory reads as an empty link
          list_head = word_index({2'b00, got}, idx) ? pool_mem[idx] : '0;
          if (used_chunks != 16'hFFFF) used_chunks++;
          for (c = 0; c < WORDS_PER_CHUNK; c++)
            if (word_index({2'b00, got} + 4 * c, idx)) pool_mem[idx] = '0;
        end
      end
      MODE_FREE: begin
        if (item.chunk_address < base_addr || {1'b0, item.chunk_address} >= pool_end) begin
          flt = FAULT_RANGE;
        end else begin
          if (word_index({2'b00, item.chunk_address}, idx)) pool_mem[idx] = list_head;
          list_head = item.chunk_address;
          if (used_chunks != '0) used_chunks--;
        end
      end
      MODE_NOP: ;
    endcase
    res.alloc_address = got;
    res.fault = flt;
    res.allocated_count = used_chunks;
    res.free_head = list_head;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      for (k = 0; k < MEM_WORDS; k++) pool_mem[k] = '0;
      base_addr = BASE_RESET;
      list_head = '0;
      used_chunks = '0;
      mismatches = 0;
      in_flight = 0;
    end else begin
      if (cfg_valid && cfg_ready) base_addr = cfg_data;
      if (in_valid && in_ready) begin
        run_pool_op(in_data, predicted);
        pending_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, actual %h", $time, out_data);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("alloc_address", oldest.alloc_address, out_data.alloc_address);
          check_field("fault", oldest.fault, out_data.fault);
          check_field("allocated_count", oldest.allocated_count, out_data.allocated_count);
          check_field("free_head", oldest.free_head, out_data.free_head);
        end
      end
      in_flight = pending_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the chunk allocator with a directed sequence (empty list, range
// faults, unaligned frees, clearing past the pool end, a head left outside
// the pool after a base change) and then random phases under several pool
// bases, with random idling on both channels, a long output stall and a
// no-idle phase. Checking is done by pool_result_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import cfla_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int          mismatches;
  int          in_flight;

  logic [31:0] base_now;
  logic [31:0] phase_base;
  bit          idle_on = 1'b1;
  bit          stall_req = 1'b0;
  int          ph;
  int          n;
  int          r;
  int          alloc_pct;

  chunk_free_list_allocator dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  pool_result_checker u_result_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .mismatches(mismatches),
    .in_flight(in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, or one long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        stall_req = 1'b0;
      end else begin
        out_ready <= idle_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_op(input mode_t m, input logic [31:0] addr);
    while (idle_on && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{mode: m, chunk_address: addr};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic write_base(input logic [31:0] b);
    drain();
    cfg_data <= b;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    base_now = b;
  endtask

  function automatic logic [31:0] pick_free_addr(input logic [31:0] b);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return b + CHUNK_BYTES * $urandom_range(0, NUM_CHUNKS - 1);
    if (sel < 75) return b + $urandom_range(0, POOL_BYTES - 1);
    if (sel < 80) return b - $urandom_range(1, (b < 256) ? b : 256);
    if (sel < 85) return b + POOL_BYTES + $urandom_range(0, 255);
    return $urandom;
  endfunction

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    base_now = BASE_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_op(MODE_ALLOC, 32'hFFFF_FFFF);            // list empty after reset
    send_op(MODE_FREE, base_now - 4);              // just below the pool
    send_op(MODE_FREE, 32'h0);
    send_op(MODE_FREE, 32'hFFFF_FFFF);
    send_op(MODE_NOP, 32'hFFFF_FFFF);
    send_op(MODE_FREE, base_now + CHUNK_BYTES);    // count already zero
    send_op(MODE_ALLOC, 32'h0);
    send_op(MODE_INIT, 32'h0);
    send_op(MODE_ALLOC, 32'h0);
    send_op(MODE_ALLOC, 32'h0);
    send_op(MODE_FREE, base_now + POOL_BYTES - 4); // last word of the pool
    send_op(MODE_ALLOC, 32'h0);                    // clearing runs past the end
    send_op(MODE_FREE, base_now + POOL_BYTES);
    send_op(MODE_FREE, base_now + POOL_BYTES - 1);
    send_op(MODE_FREE, base_now + 3);
    send_op(MODE_ALLOC, 32'h0);
    send_op(MODE_ALLOC, 32'h0);
    send_op(MODE_NOP, 32'h0);
    // head stays below the new base, so the next pop reads an empty link
    write_base(32'd8192);
    send_op(MODE_ALLOC, 32'h0);
    send_op(MODE_ALLOC, 32'h0);
    send_op(MODE_INIT, 32'h0);

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       phase_base = 32'd4;
        1:       phase_base = 32'hFFFF_0000;
        2:       phase_base = BASE_RESET;
        default: phase_base = $urandom_range(1, 32'h3FFF_C000) << 2;
      endcase
      idle_on = (ph != 3);
      write_base(phase_base);
      send_op(MODE_INIT, $urandom);
      alloc_pct = 45;
      for (n = 0; n < 240; n++) begin
        if (ph == 2 && n == 100) stall_req = 1'b1;
        // bursts that mostly pop run the list dry, mixed ones keep it churning
        if (n % 30 == 0) alloc_pct = ($urandom_range(0, 99) < 40) ? 85 : 45;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) send_op(MODE_ALLOC, $urandom);
        else if (r < 94)   send_op(MODE_FREE, pick_free_addr(base_now));
        else if (r < 97)   send_op(MODE_NOP, $urandom);
        else               send_op(MODE_INIT, $urandom);
      end
      drain();
    end

    idle_on = 1'b0;
    repeat (80) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/cfla_pkg.sv
src/cfla_map.sv
src/cfla_engine.sv
src/chunk_free_list_allocator.sv
src/cfla_checker.sv
tb/pool_result_checker.sv
tb/tb_top.sv
